FILE: rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum unit.
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_REQ,
        ST_HEAD_CHK,
        ST_TAIL_REQ,
        ST_TAIL_CHK,
        ST_PUSH,
        ST_OUT_REQ,
        ST_OUT_LOAD
    } swm_state_t;

endpackage

FILE: rtl/swm_deque_mem.sv
// Deque storage: value and position per entry, one write and one registered read port.
module swm_deque_mem
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int AW           = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    parameter int PW           = $clog2(2 * WINDOW_MAX)
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [SAMPLE_WIDTH-1:0] wr_value,
    input  logic [PW-1:0]           wr_pos,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic [SAMPLE_WIDTH-1:0] rd_value,
    output logic [PW-1:0]           rd_pos
);

    logic [SAMPLE_WIDTH-1:0] value_mem [WINDOW_MAX];
    logic [PW-1:0]           pos_mem   [WINDOW_MAX];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            pos_mem[wr_addr]   <= wr_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_value <= value_mem[rd_addr];
            rd_pos   <= pos_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/sliding_window_maximum_unit.sv
// Sliding window maximum unit: top level with deque sequencer and output register.
//
// Usage: samples enter on the in_valid/in_ready channel with sample and last_in.
// Once window_len samples of the current stream have arrived, each sample yields
// one item on out_valid/out_ready: window_max of the last window_len samples,
// with last_out set on the item caused by the stream's final sample. A stream
// shorter than the window gives no items. last_in clears the stream state.
// window_len is written through cfg_wr_en/cfg_wr_data, by the user only while
// the unit is idle (the block does not enforce it); zero acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX. Sequence: after acceptance a sample runs
// head read and check states until the head entry is young enough, tail read and
// check states until the tail entry is not popped, then push, output read and
// output load; a deque that runs empty skips the remaining checks, and a sample
// with no result returns to idle from the output read. The deque memory has one
// read port with registered data, so each drop or pop costs a read state and a
// check state. Each sample pops at most once amortized. in_ready is high only
// while the sequencer is idle. A finished item waits in the output register; the
// next sample is still taken, and the sequencer holds only when it must load a
// new item while the previous one is not yet taken. Reset empties the deque,
// clears out_valid and sets window_len to 1; memory contents need no clearing.
module sliding_window_maximum_unit
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]    cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    last_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0] window_max,
    output logic                    last_out
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int PW = $clog2(2 * WINDOW_MAX);

    localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [PW-1:0] POS_LAST = PW'(2 * WINDOW_MAX - 1);
    localparam logic [PW:0]   POS_MOD  = (PW + 1)'(2 * WINDOW_MAX);
    localparam logic [CW-1:0] CNT_MAX  = CW'(WINDOW_MAX);

    swm_state_t state_reg, state_next;

    logic [CFG_WIDTH-1:0]    window_len_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic                    last_reg;
    logic [CW-1:0]           win_reg;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           seen_reg, seen_next;

    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] window_max_reg;
    logic                    last_out_reg;

    logic                    mem_wr_en;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_value;
    logic [PW-1:0]           rd_pos;

    logic [31:0]             wl32;
    logic [31:0]             eff32;
    logic [CW-1:0]           win_eff;
    logic [PW:0]             age;
    logic                    head_old;
    logic                    tail_pop;
    logic                    produce;
    logic                    out_load;
    logic                    finish;
    logic                    accept;
    logic [AW-1:0]           tail_prev;

    assign accept = in_valid && in_ready;

    assign wl32    = 32'(window_len_reg);
    assign eff32   = (wl32 == 32'd0) ? 32'd1 :
                     (wl32 > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : wl32;
    assign win_eff = eff32[CW-1:0];

    assign age = (pos_reg >= rd_pos) ? ({1'b0, pos_reg} - {1'b0, rd_pos})
                                     : ({1'b0, pos_reg} + POS_MOD - {1'b0, rd_pos});
    assign head_old  = 32'(age) >= 32'(win_reg);
    assign tail_pop  = $signed(rd_value) <= $signed(sample_reg);
    assign produce   = (seen_reg >= win_reg) && (count_reg != '0);
    assign out_load  = (state_reg == ST_OUT_LOAD) && (!out_valid_reg || out_ready);
    assign finish    = out_load || ((state_reg == ST_OUT_REQ) && !produce);
    assign tail_prev = (tail_reg == '0) ? PTR_LAST : tail_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_HEAD_REQ;
            ST_HEAD_REQ: state_next = (count_reg == '0) ? ST_PUSH : ST_HEAD_CHK;
            ST_HEAD_CHK: state_next = head_old ? ST_HEAD_REQ : ST_TAIL_REQ;
            ST_TAIL_REQ: state_next = (count_reg == '0) ? ST_PUSH : ST_TAIL_CHK;
            ST_TAIL_CHK: state_next = tail_pop ? ST_TAIL_REQ : ST_PUSH;
            ST_PUSH:     state_next = ST_OUT_REQ;
            ST_OUT_REQ:  state_next = produce ? ST_OUT_LOAD : ST_IDLE;
            ST_OUT_LOAD: if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;
        unique case (state_reg)
            ST_IDLE:     in_ready = 1'b1;
            ST_HEAD_REQ: mem_rd_en = (count_reg != '0);
            ST_TAIL_REQ:
            begin
                mem_rd_en   = (count_reg != '0);
                mem_rd_addr = tail_prev;
            end
            ST_PUSH:     mem_wr_en = (count_reg < CNT_MAX);
            ST_OUT_REQ:  mem_rd_en = produce;
            default:     ;
        endcase
    end

    // deque pointers and stream counters
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        if (state_reg == ST_HEAD_CHK && head_old)
        begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (state_reg == ST_TAIL_CHK && tail_pop)
        begin
            tail_next  = tail_prev;
            count_next = count_reg - 1'b1;
        end
        if (state_reg == ST_PUSH)
        begin
            if (count_reg < CNT_MAX)
            begin
                tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            if (seen_reg < CNT_MAX)
                seen_next = seen_reg + 1'b1;
        end
        if (finish && last_reg)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            pos_next   = '0;
            seen_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= CFG_WIDTH'(1);
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                window_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            last_reg   <= last_in;
            win_reg    <= win_eff;
        end
        if (out_load)
        begin
            window_max_reg <= rd_value;
            last_out_reg   <= last_reg;
        end
    end

    swm_deque_mem #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW),
        .PW           (PW)
    ) u_deque_mem (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (tail_reg),
        .wr_value (sample_reg),
        .wr_pos   (pos_reg),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_value (rd_value),
        .rd_pos   (rd_pos)
    );

    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;
    assign last_out   = last_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("deque entry count above depth");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |=> (count_reg != '0))
        else $error("deque empty after push");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new item taken while sequencer busy");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == ST_OUT_LOAD)
            |=> (state_reg == ST_OUT_LOAD))
        else $error("result dropped while output register full");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_MAX)
        else $error("sample count above window limit");

endmodule

FILE: sim/tb_top.sv
// Testbench for sliding_window_maximum_unit: directed and random streams checked against a deque model.
module tb_top;
    import swm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W       = $clog2(WINDOW_MAX_DEF);
    localparam int POS_W       = PTR_W + 1;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [SAMPLE_WIDTH_DEF-1:0] window_max;
        logic                        last;
    } max_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_WIDTH-1:0]        cfg_wr_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [SAMPLE_WIDTH_DEF-1:0] sample = '0;
    logic                        last_in = 1'b0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [SAMPLE_WIDTH_DEF-1:0] window_max;
    logic                        last_out;

    // deque model
    logic [CFG_WIDTH-1:0]        win_reg = 7'd1;
    logic [SAMPLE_WIDTH_DEF-1:0] dq_val [WINDOW_MAX_DEF];
    logic [POS_W-1:0]            dq_pos [WINDOW_MAX_DEF];
    logic [PTR_W-1:0]            dq_head = '0;
    logic [PTR_W-1:0]            dq_tail = '0;
    logic [POS_W-1:0]            dq_count = '0;
    logic [POS_W-1:0]            next_pos = '0;
    logic [POS_W-1:0]            seen = '0;

    max_result_t                 pending_max_q [$];
    int                          err_count = 0;
    int                          in_idle_pct = 20;
    int                          out_stall_pct = 20;
    logic [SAMPLE_WIDTH_DEF-1:0] ramp_val = '0;

    sliding_window_maximum_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_max  (window_max),
        .last_out    (last_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int effective_len(input logic [CFG_WIDTH-1:0] w);
        if (w == 0)
            return 1;
        if (w > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return int'(w);
    endfunction

    function automatic void predict_window_max(input logic [SAMPLE_WIDTH_DEF-1:0] s,
                                               input logic l);
        int               w;
        logic [POS_W-1:0] age;
        logic [PTR_W-1:0] idx;
        max_result_t      r;
        w = effective_len(win_reg);
        while (dq_count != 0)
        begin
            age = next_pos - dq_pos[dq_head];
            if (age < w)
                break;
            dq_head++;
            dq_count--;
        end
        while (dq_count != 0)
        begin
            idx = dq_tail - 1'b1;
            if ($signed(dq_val[idx]) > $signed(s))
                break;
            dq_tail = idx;
            dq_count--;
        end
        if (dq_count < WINDOW_MAX_DEF)
        begin
            dq_val[dq_tail] = s;
            dq_pos[dq_tail] = next_pos;
            dq_tail++;
            dq_count++;
        end
        next_pos++;
        if (seen < WINDOW_MAX_DEF)
            seen++;
        if (seen >= w && dq_count != 0)
        begin
            r.window_max = dq_val[dq_head];
            r.last       = l;
            pending_max_q.push_back(r);
        end
        if (l)
        begin
            dq_head  = '0;
            dq_tail  = '0;
            dq_count = '0;
            next_pos = '0;
            seen     = '0;
        end
    endfunction

    function automatic logic [SAMPLE_WIDTH_DEF-1:0] next_sample(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($urandom_range(0, 8)) - 32'd4;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return '0;
                    default: return '1;
                endcase
            end
            3: ramp_val = ramp_val + 32'($urandom_range(0, 8)) - 32'd4;
            4: ramp_val = ramp_val - 32'($urandom_range(0, 3));
            default: ramp_val = ramp_val + 32'($urandom_range(0, 3));
        endcase
        return ramp_val;
    endfunction

    function automatic void note_failure(input string msg);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("%t: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

    always @(posedge clk)
    begin
        max_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_max_q.size() == 0)
                note_failure($sformatf("unexpected item max=%0d last=%0b",
                                       $signed(window_max), last_out));
            else
            begin
                exp_r = pending_max_q.pop_front();
                if (window_max !== exp_r.window_max || last_out !== exp_r.last)
                    note_failure($sformatf("mismatch: expected max=%0d last=%0b, got max=%0d last=%0b",
                                           $signed(exp_r.window_max), exp_r.last,
                                           $signed(window_max), last_out));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_WIDTH_DEF-1:0] s, input logic l);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last_in  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_window_max(s, l);
    endtask

    // wait until every expected item is out and the sequencer has gone quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_max_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        win_reg = w;
    endtask

    task automatic test_reset_window_extremes();
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
    endtask

    task automatic test_window_zero();
        settle_block();
        write_window('0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h5555_aaaa, 1'b1);
    endtask

    task automatic test_ties_and_runs();
        settle_block();
        write_window(7'd3);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'hffff_fffe, 1'b0);
        send_sample(32'd7, 1'b1);
    endtask

    task automatic test_short_stream();
        settle_block();
        write_window(7'd8);
        send_sample(32'd10, 1'b0);
        send_sample(32'd20, 1'b0);
        send_sample(32'd30, 1'b1);
    endtask

    task automatic test_midstream_window_change();
        settle_block();
        write_window(7'd4);
        send_sample(32'd9, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd8, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd7, 1'b0);
        settle_block();
        write_window(7'd2);
        send_sample(32'd3, 1'b0);
        send_sample(32'd6, 1'b0);
        settle_block();
        write_window(7'd12);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd3, 1'b1);
    endtask

    task automatic test_random_streams(input int n_items);
        int                   sent;
        int                   len;
        int                   mode;
        int                   pick;
        int                   weff;
        logic                 l;
        logic [CFG_WIDTH-1:0] w;
        sent = 0;
        while (sent < n_items)
        begin
            settle_block();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                w = '0;
            else if (pick < 10)
                w = 7'd64;
            else if (pick < 13)
                w = 7'd127;
            else if (pick < 16)
                w = 7'($urandom_range(65, 126));
            else if (pick < 24)
                w = 7'($urandom_range(33, 63));
            else
                w = 7'($urandom_range(1, 12));
            write_window(w);
            weff = effective_len(w);
            repeat ($urandom_range(1, 3))
            begin
                mode = $urandom_range(0, 5);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = $urandom_range(1, weff);
                else if (pick < 25 && weff <= 16)
                    len = weff + $urandom_range(130, 200);
                else
                    len = weff + $urandom_range(0, 2 * weff + 4);
                for (int k = 0; k < len && sent < n_items; k++)
                begin
                    in_idle_pct   = (sent >= 500 && sent < 800) ? 0 : 20;
                    out_stall_pct = in_idle_pct;
                    if (k > 0 && $urandom_range(0, 199) == 0)
                    begin
                        settle_block();
                        write_window(7'($urandom_range(0, 70)));
                    end
                    l = (k == len - 1) || ($urandom_range(0, 99) == 0);
                    send_sample(next_sample(mode), l);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window_extremes();
        test_window_zero();
        test_ties_and_runs();
        test_short_stream();
        test_midstream_window_change();
        test_random_streams(1525);
        settle_block();
        if (err_count == 0 && pending_max_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
